// ----- hdl/event_timer_bank_top_assert.svh -----
// Assertion macros shared by the event timer bank modules.
// No dependencies; the including module supplies clock and reset names.
`ifndef EVENT_TIMER_BANK_TOP_ASSERT_SVH
`define EVENT_TIMER_BANK_TOP_ASSERT_SVH
`ifndef SYNTH
`define ETB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("event timer bank check failed");
`define ETB_NEVER(lbl, clk, rst_n, cond) \
    `ETB_ASSERT(lbl, clk, rst_n, !(cond))
`else
`define ETB_ASSERT(lbl, clk, rst_n, prop)
`define ETB_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ----- hdl/etb_pkg.sv -----
// Types and constants of the event timer bank.
// No dependencies.
`default_nettype none
package etb_pkg;

    localparam int NUM_TIMERS_DEF = 8;
    localparam int IDX_W          = 3;
    localparam int MAX_ADDR       = 2 ** IDX_W;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_START = 2'd1,
        REQ_STOP  = 2'd2
    } t_req_kind;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [IDX_W-1:0] timer_index;
        logic [7:0]       dest_queue;
        logic [15:0]      event_code;
        logic [31:0]      first_arg;
        logic [31:0]      second_arg;
        logic [15:0]      interval_ticks;
        logic             repeat_enable;
    } t_req;

    typedef struct packed {
        logic [IDX_W-1:0] expired_index;
        logic [7:0]       out_dest;
        logic [15:0]      out_event;
        logic [31:0]      out_first;
        logic [31:0]      out_second;
        logic             last_of_tick;
    } t_res;

    typedef struct packed {
        logic tick;
        logic start;
        logic stop;
        logic step;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic expiring;
        logic at_end;
        logic out_busy;
    } t_stat;

endpackage
`default_nettype wire

// ----- hdl/etb_if.sv -----
// Valid/ready channel interfaces for requests and expiry results.
// Depends on etb_pkg for the payload types.
`default_nettype none
interface etb_req_if import etb_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface etb_res_if import etb_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/etb_ctrl.sv -----
// Controller of the event timer bank: request decode and tick walk sequencing.
// Depends on etb_pkg and the assertion macro header.
`default_nettype none
`include "event_timer_bank_top_assert.svh"
module etb_ctrl import etb_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_req_valid,
    input  wire logic [1:0] i_req_type,
    input  wire t_stat      i_stat,
    output logic            o_req_ready,
    output t_cmd            o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.tick) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (o_cmd.step && i_stat.at_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_req_ready = (r_state == ST_IDLE);
        accept      = i_req_valid && o_req_ready;
        o_cmd.tick  = accept && (i_req_type == REQ_TICK);
        o_cmd.start = accept && (i_req_type == REQ_START);
        o_cmd.stop  = accept && (i_req_type == REQ_STOP);
        // hold the walk while an expiry cannot be handed to the output register
        o_cmd.step  = (r_state == ST_WALK) && (!i_stat.expiring || !i_stat.out_busy);
        o_cmd.load  = o_cmd.step && i_stat.expiring;
    end

    `ETB_ASSERT(a_load_steps, i_clk, i_rst_n, o_cmd.load |-> o_cmd.step)
    `ETB_ASSERT(a_end_idle, i_clk, i_rst_n, (o_cmd.step && i_stat.at_end) |=> (r_state == ST_IDLE))
    `ETB_NEVER(a_no_step_idle, i_clk, i_rst_n, (r_state == ST_IDLE) && o_cmd.step)
    `ETB_NEVER(a_no_req_walk, i_clk, i_rst_n, (r_state == ST_WALK) && (o_cmd.tick || o_cmd.start || o_cmd.stop))

endmodule
`default_nettype wire

// ----- hdl/etb_datapath.sv -----
// Datapath of the event timer bank: timer storage, walk index and result register.
// Depends on etb_pkg and the assertion macro header.
`default_nettype none
`include "event_timer_bank_top_assert.svh"
module etb_datapath import etb_pkg::*; #(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_req i_req,
    input  wire t_cmd i_cmd,
    input  wire logic i_out_ready,
    output t_stat     o_stat,
    output logic      o_out_valid,
    output t_res      o_out
);

    // only the timers reachable by timer_index are stored
    localparam int NT = (NUM_TIMERS < MAX_ADDR) ? NUM_TIMERS : MAX_ADDR;
    localparam int IW = (NT > 1) ? $clog2(NT) : 1;

    logic [15:0]   r_remaining [NT];
    logic [15:0]   r_reload    [NT];
    logic          r_repeat    [NT];
    logic [7:0]    r_dest      [NT];
    logic [15:0]   r_event     [NT];
    logic [31:0]   r_first     [NT];
    logic [31:0]   r_second    [NT];
    logic [NT-1:0] r_mask;
    logic [NT-1:0] n_mask;
    logic [IW-1:0] r_idx;
    logic          r_out_valid;
    t_res          r_out;

    logic          wr_ok;
    logic [IW-1:0] wr_idx;
    logic [15:0]   cur;
    logic          last;

    always_comb begin
        wr_ok  = ({1'b0, i_req.timer_index} < (IDX_W + 1)'(NT));
        wr_idx = i_req.timer_index[IW-1:0];
        cur    = r_remaining[r_idx];
        for (int t = 0; t < NT; t++) begin
            n_mask[t] = (r_remaining[t] == 16'd1);
        end
        last            = (((r_mask >> r_idx) >> 1) == '0);
        o_stat.expiring = (cur == 16'd1);
        o_stat.at_end   = (r_idx == IW'(NT - 1));
        o_stat.out_busy = r_out_valid && !i_out_ready;
        o_out_valid     = r_out_valid;
        o_out           = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < NT; t++) begin
                r_remaining[t] <= '0;
                r_reload[t]    <= '0;
            end
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start && wr_ok) begin
                r_remaining[wr_idx] <= i_req.interval_ticks;
                r_reload[wr_idx]    <= i_req.interval_ticks;
            end
            if (i_cmd.stop && wr_ok) begin
                r_remaining[wr_idx] <= '0;
                r_reload[wr_idx]    <= '0;
            end
            if (i_cmd.tick) begin
                r_idx <= '0;
            end
            if (i_cmd.step) begin
                if (cur != 16'd0) begin
                    if (o_stat.expiring) begin
                        r_remaining[r_idx] <= r_repeat[r_idx] ? r_reload[r_idx] : 16'd0;
                    end else begin
                        r_remaining[r_idx] <= cur - 16'd1;
                    end
                end
                r_idx <= o_stat.at_end ? '0 : r_idx + IW'(1);
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start && wr_ok) begin
            r_repeat[wr_idx] <= i_req.repeat_enable;
            r_dest[wr_idx]   <= i_req.dest_queue;
            r_event[wr_idx]  <= i_req.event_code;
            r_first[wr_idx]  <= i_req.first_arg;
            r_second[wr_idx] <= i_req.second_arg;
        end
        if (i_cmd.tick) begin
            r_mask <= n_mask;
        end
        if (i_cmd.load) begin
            r_out.expired_index <= IDX_W'(r_idx);
            r_out.out_dest      <= r_dest[r_idx];
            r_out.out_event     <= r_event[r_idx];
            r_out.out_first     <= r_first[r_idx];
            r_out.out_second    <= r_second[r_idx];
            r_out.last_of_tick  <= last;
        end
    end

    `ETB_ASSERT(a_load_free, i_clk, i_rst_n, i_cmd.load |-> (!r_out_valid || i_out_ready))
    `ETB_ASSERT(a_load_shows, i_clk, i_rst_n, i_cmd.load |=> r_out_valid)
    `ETB_ASSERT(a_walk_start, i_clk, i_rst_n, i_cmd.tick |=> (r_idx == '0))

endmodule
`default_nettype wire

// ----- hdl/event_timer_bank_top.sv -----
// A tick request walks the stored timers one per cycle, holding the walk while an
// expiry waits on a full result register; it visits NUM_TIMERS timers, at most
// eight, since only eight can be addressed.
// Each expiring timer gives one result, the final one of a tick flagged last.
// Top level of the event timer bank; depends on etb_pkg, etb_if, etb_ctrl and
// etb_datapath.
`default_nettype none
module event_timer_bank_top import etb_pkg::*; #(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    etb_req_if.sink    i_req,
    etb_res_if.source  o_res
);

    t_cmd  cmd;
    t_stat stat;

    etb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (i_req.data.req_type),
        .i_stat      (stat),
        .o_req_ready (i_req.ready),
        .o_cmd       (cmd)
    );

    etb_datapath #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req.data),
        .i_cmd       (cmd),
        .i_out_ready (o_res.ready),
        .o_stat      (stat),
        .o_out_valid (o_res.valid),
        .o_out       (o_res.data)
    );

endmodule
`default_nettype wire

// ----- tb/tb_event_timer_bank_top.sv -----
// Self-checking testbench for event_timer_bank_top: directed table, then random requests.
// Expected expiries come from a bank model or typed table rows; uses etb_pkg and etb_if.
`timescale 1ns / 1ps

module tb_event_timer_bank_top;
    import etb_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int RAND_ITEMS  = 100;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN       = 4 * NUM_TIMERS_DEF + 16;

    typedef struct {
        t_req req;
        bit   typed;
        t_res exp;
    } t_plan_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic rcv_ready = 1'b0;

    etb_req_if req_ch();
    etb_res_if res_ch();

    assign res_ch.ready = rcv_ready;

    event_timer_bank_top #(
        .NUM_TIMERS(NUM_TIMERS_DEF)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    logic [15:0] ticks_left [NUM_TIMERS_DEF];
    logic [15:0] reload_ticks [NUM_TIMERS_DEF];
    logic        auto_repeat [NUM_TIMERS_DEF];
    logic [7:0]  held_dest [NUM_TIMERS_DEF];
    logic [15:0] held_event [NUM_TIMERS_DEF];
    logic [31:0] held_first [NUM_TIMERS_DEF];
    logic [31:0] held_second [NUM_TIMERS_DEF];

    t_res      expiries [$];
    t_plan_row plan [$];
    bit        calm = 1'b0;
    int        errors = 0;
    int        cycles = 0;
    int        stall_left = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rcv_ready  <= 1'b0;
        end else begin
            rcv_ready <= 1'b1;
            if (!calm && $urandom_range(0, 2) == 0) begin
                stall_left <= pick_gap();
            end
        end
    end

    function automatic t_req mk_req(logic [1:0] kind, logic [IDX_W-1:0] idx, logic [7:0] dest,
                                    logic [15:0] evt, logic [31:0] a, logic [31:0] b,
                                    logic [15:0] ivl, logic rep);
        t_req r;
        r.req_type       = kind;
        r.timer_index    = idx;
        r.dest_queue     = dest;
        r.event_code     = evt;
        r.first_arg      = a;
        r.second_arg     = b;
        r.interval_ticks = ivl;
        r.repeat_enable  = rep;
        return r;
    endfunction

    // Apply one request to the model bank; queue the expiries it fires when keep is set.
    function automatic void step_bank(input t_req r, input bit keep);
        t_res hits [NUM_TIMERS_DEF];
        int   n;
        int   i;
        i = r.timer_index;
        n = 0;
        case (r.req_type)
            REQ_START: begin
                held_dest[i]    = r.dest_queue;
                held_event[i]   = r.event_code;
                held_first[i]   = r.first_arg;
                held_second[i]  = r.second_arg;
                ticks_left[i]   = r.interval_ticks;
                reload_ticks[i] = r.interval_ticks;
                auto_repeat[i]  = r.repeat_enable;
            end
            REQ_STOP: begin
                ticks_left[i]   = '0;
                reload_ticks[i] = '0;
            end
            REQ_TICK: begin
                for (int t = 0; t < NUM_TIMERS_DEF; t++) begin
                    if (ticks_left[t] != 16'd0) begin
                        ticks_left[t] = ticks_left[t] - 16'd1;
                        if (ticks_left[t] == 16'd0) begin
                            if (auto_repeat[t]) ticks_left[t] = reload_ticks[t];
                            hits[n].expired_index = IDX_W'(t);
                            hits[n].out_dest      = held_dest[t];
                            hits[n].out_event     = held_event[t];
                            hits[n].out_first     = held_first[t];
                            hits[n].out_second    = held_second[t];
                            hits[n].last_of_tick  = 1'b0;
                            n++;
                        end
                    end
                end
                for (int k = 0; k < n; k++) begin
                    hits[k].last_of_tick = (k == n - 1);
                    if (keep) expiries.push_back(hits[k]);
                end
            end
            default: ;
        endcase
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
        if (exp !== act) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp, act);
        end
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expiries.size() == 0) begin
                errors++;
                $display("%0t: unexpected expiry, expected none, got %h", $time, res_ch.data);
            end else begin
                want = expiries.pop_front();
                check_field("expired_index", 32'(want.expired_index),
                            32'(res_ch.data.expired_index));
                check_field("out_dest", 32'(want.out_dest), 32'(res_ch.data.out_dest));
                check_field("out_event", 32'(want.out_event), 32'(res_ch.data.out_event));
                check_field("out_first", want.out_first, res_ch.data.out_first);
                check_field("out_second", want.out_second, res_ch.data.out_second);
                check_field("last_of_tick", 32'(want.last_of_tick),
                            32'(res_ch.data.last_of_tick));
            end
        end
    end

    task automatic send_req(input t_req r, input bit typed, input t_res typed_exp);
        int gap;
        req_ch.data  <= r;
        req_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
        step_bank(r, !typed);
        if (typed) expiries.push_back(typed_exp);
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        t_req r;
        int   counted;
        int   sel;
        int   p;
        bit   paused;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        counted = 0;
        paused  = 1'b0;
        for (int t = 0; t < NUM_TIMERS_DEF; t++) begin
            ticks_left[t]   = '0;
            reload_ticks[t] = '0;
            auto_repeat[t]  = 1'b0;
            held_dest[t]    = '0;
            held_event[t]   = '0;
            held_first[t]   = '0;
            held_second[t]  = '0;
        end

        plan.push_back('{mk_req(REQ_TICK, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        plan.push_back('{mk_req(REQ_START, 0, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                16'd1, 1'b0), 1'b0, '0});
        plan.push_back('{mk_req(REQ_TICK, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                         '{3'd0, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}});
        plan.push_back('{mk_req(REQ_TICK, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        plan.push_back('{mk_req(REQ_START, 7, 8'hA5, 16'h5A5A, 32'h1234_5678, 32'h9ABC_DEF0,
                                16'd0, 1'b1), 1'b0, '0});
        plan.push_back('{mk_req(REQ_TICK, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        plan.push_back('{mk_req(REQ_START, 7, 8'h5A, 16'hA5A5, 32'hDEAD_BEEF, 32'h0F0F_F0F0,
                                16'd2, 1'b1), 1'b0, '0});
        plan.push_back('{mk_req(REQ_START, 3, 8'h00, 16'h0000, 32'h0, 32'h0, 16'd1, 1'b1),
                         1'b0, '0});
        plan.push_back('{mk_req(REQ_TICK, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                         '{3'd3, 8'h00, 16'h0000, 32'h0, 32'h0, 1'b1}});
        plan.push_back('{mk_req(REQ_TICK, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        plan.push_back('{mk_req(REQ_UNUSED, 1, 8'h11, 16'h2222, 32'h3, 32'h4, 16'd1, 1'b1),
                         1'b0, '0});
        plan.push_back('{mk_req(REQ_STOP, 3, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        plan.push_back('{mk_req(REQ_TICK, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        plan.push_back('{mk_req(REQ_START, 5, 8'h3C, 16'h8001, 32'h8000_0001, 32'h7FFF_FFFE,
                                16'hFFFF, 1'b0), 1'b0, '0});
        plan.push_back('{mk_req(REQ_STOP, 5, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        plan.push_back('{mk_req(REQ_STOP, 7, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        for (int t = 0; t < NUM_TIMERS_DEF; t++) begin
            plan.push_back('{mk_req(REQ_START, IDX_W'(t), 8'(8'h10 + t), 16'(16'h0100 * t),
                                    32'h0101_0101 * t, ~(32'h0101_0101 * t), 16'd1, t[0]),
                             1'b0, '0});
        end
        plan.push_back('{mk_req(REQ_TICK, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) send_req(plan[k].req, plan[k].typed, plan[k].exp);

        while (counted < RAND_ITEMS) begin
            calm = (counted >= 40 && counted < 70);
            r.req_type       = 2'(REQ_TICK);
            r.timer_index    = IDX_W'($urandom);
            r.dest_queue     = 8'($urandom);
            r.event_code     = 16'($urandom);
            r.first_arg      = $urandom;
            r.second_arg     = $urandom;
            r.interval_ticks = 16'($urandom_range(1, 5));
            r.repeat_enable  = 1'($urandom);
            sel = $urandom_range(0, 99);
            p   = $urandom_range(0, 99);
            if (sel < 45) r.req_type = REQ_TICK;
            else if (sel < 80) r.req_type = REQ_START;
            else if (sel < 94) r.req_type = REQ_STOP;
            else r.req_type = REQ_UNUSED;
            if (p < 6) r.interval_ticks = '0;
            else if (p < 12) r.interval_ticks = 16'($urandom);
            send_req(r, 1'b0, '0);
            if (r.req_type != REQ_UNUSED) counted++;
            if (!paused && counted == 90) begin
                paused = 1'b1;
                req_ch.valid <= 1'b0;
                do @(posedge i_clk); while (expiries.size() != 0);
            end
        end
        calm = 1'b0;

        req_ch.valid <= 1'b0;
        while (expiries.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/etb_pkg.sv
hdl/etb_if.sv
hdl/etb_ctrl.sv
hdl/etb_datapath.sv
hdl/event_timer_bank_top.sv
tb/tb_event_timer_bank_top.sv
